FILE: sv/btpm_pkg.sv
// Shared codes and constants for the binary trie prefix match block.
`default_nettype none
package btpm_pkg;

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Route field value of a node that holds no route.
    localparam logic [8:0] NO_ROUTE = 9'd256;

    localparam int HOP_W   = 8;
    localparam int ROUTE_W = 9;

endpackage
`default_nettype wire

FILE: sv/btpm_node_ram.sv
// Node pool memory: one write port and one read port with registered read data.
`default_nettype none
module btpm_node_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 33
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: sv/binary_trie_prefix_match.sv
// Top level of the binary trie longest prefix match for IPv6 routes.
//
// Input channel: i_valid / o_stall carry one insert or lookup request per
// transaction. Output channel: o_valid / i_stall carry one result per request,
// in request order. A request is taken only while the block is idle, with no
// other request walking or waiting for the output register. Each request
// walks the trie one level per cycle, with one node memory read or write per
// level. A lookup walks until its path ends, at most ADDR_BITS levels deep.
// An insert walks to its prefix length (saturated at ADDR_BITS), stopping
// early when the pool runs out; a zero-length insert does not walk. The next
// request is taken the cycle after a result moves to the output register.
// A finished result waits in a holding register while the output
// register is stalled; the output holds its payload until it is taken.
// Reset empties the trie (root only, no routes) and drops any pending result.
// The node pool is never cleared: every node is fully written when allocated.
`default_nettype none
module binary_trie_prefix_match #(
    parameter int NODES     = 4096,
    parameter int ADDR_BITS = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [63:0] i_addr_hi,
    input  wire logic [63:0] i_addr_lo,
    input  wire logic [7:0]  i_prefix_len,
    input  wire logic [7:0]  i_next_hop_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [7:0]       o_next_hop,
    output logic             o_status
);

    localparam int IDXW = $clog2(NODES);
    localparam int LVLW = $clog2(ADDR_BITS + 1);
    localparam int W    = 2 * IDXW + btpm_pkg::ROUTE_W;
    localparam logic [IDXW:0]   POOL_SIZE = (IDXW + 1)'(NODES);
    localparam logic [LVLW-1:0] LVL_MAX   = LVLW'(ADDR_BITS);
    localparam logic [7:0]      LEN_MAX   = 8'(ADDR_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_is_lookup, n_is_lookup;
    logic [ADDR_BITS-1:0]    r_addr, n_addr;
    logic [LVLW-1:0]         r_len, n_len;
    logic [LVLW-1:0]         r_level, n_level;
    logic [IDXW-1:0]         r_cur, n_cur;
    logic [IDXW:0]           r_fresh, n_fresh;
    logic [7:0]              r_hop_in, n_hop_in;
    logic                    r_hit, n_hit;
    logic [7:0]              r_hop, n_hop;
    logic [IDXW-1:0]         r_root_l, n_root_l;
    logic [IDXW-1:0]         r_root_r, n_root_r;
    logic                    r_res_hit, n_res_hit;
    logic [7:0]              r_res_hop, n_res_hop;
    logic                    r_res_status, n_res_status;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_hit, n_out_hit;
    logic [7:0]              r_out_hop, n_out_hop;
    logic                    r_out_status, n_out_status;

    logic                    ram_we;
    logic [IDXW-1:0]         ram_waddr;
    logic [W-1:0]            ram_wdata;
    logic [W-1:0]            ram_rdata;

    logic [127:0]            full_addr;
    logic [7:0]              len_sat;
    logic [IDXW-1:0]         cur_left, cur_right, child;
    logic [8:0]              cur_route;
    logic                    bit_now;
    logic                    route_here;
    logic                    fresh_left;

    assign full_addr = {i_addr_hi, i_addr_lo};
    assign len_sat   = (i_prefix_len > LEN_MAX) ? LEN_MAX : i_prefix_len;

    // The root never holds a route, so only its two child links are kept in flops.
    assign cur_left   = (r_cur == '0) ? r_root_l : ram_rdata[W-1 -: IDXW];
    assign cur_right  = (r_cur == '0) ? r_root_r : ram_rdata[W-IDXW-1 -: IDXW];
    assign cur_route  = (r_cur == '0) ? btpm_pkg::NO_ROUTE : ram_rdata[8:0];
    assign bit_now    = r_addr[ADDR_BITS-1];
    assign child      = bit_now ? cur_right : cur_left;
    assign route_here = (cur_route != btpm_pkg::NO_ROUTE);
    assign fresh_left = (r_fresh != POOL_SIZE);

    btpm_node_ram #(
        .DEPTH(NODES),
        .WIDTH(W)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(n_cur),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_is_lookup  = r_is_lookup;
        n_addr       = r_addr;
        n_len        = r_len;
        n_level      = r_level;
        n_cur        = r_cur;
        n_fresh      = r_fresh;
        n_hop_in     = r_hop_in;
        n_hit        = r_hit;
        n_hop        = r_hop;
        n_root_l     = r_root_l;
        n_root_r     = r_root_r;
        n_res_hit    = r_res_hit;
        n_res_hop    = r_res_hop;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_stall;
        n_out_hit    = r_out_hit;
        n_out_hop    = r_out_hop;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = {cur_left, cur_right, cur_route};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_is_lookup  = (i_req_type == btpm_pkg::REQ_LOOKUP);
                    n_addr       = full_addr[ADDR_BITS-1:0];
                    n_len        = LVLW'(len_sat);
                    n_level      = '0;
                    n_cur        = '0;
                    n_hop_in     = i_next_hop_in;
                    n_hit        = 1'b0;
                    n_hop        = '0;
                    if (i_req_type == btpm_pkg::REQ_INSERT && i_prefix_len == 8'd0) begin
                        n_res_hit    = 1'b0;
                        n_res_hop    = '0;
                        n_res_status = btpm_pkg::STATUS_OK;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_is_lookup) begin
                    if (route_here) begin
                        n_hit = 1'b1;
                        n_hop = cur_route[7:0];
                    end
                    if (r_level == LVL_MAX || child == '0) begin
                        n_res_hit    = route_here || r_hit;
                        n_res_hop    = route_here ? cur_route[7:0] : r_hop;
                        n_res_status = btpm_pkg::STATUS_OK;
                        n_state      = S_DONE;
                    end else begin
                        n_cur   = child;
                        n_level = r_level + 1'b1;
                        n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                    end
                end else if (r_level == r_len) begin
                    // Reached the prefix node: the first route stored here wins.
                    if (!route_here) begin
                        ram_we    = 1'b1;
                        ram_wdata = {cur_left, cur_right, 1'b0, r_hop_in};
                    end
                    n_res_hit    = 1'b0;
                    n_res_hop    = '0;
                    n_res_status = btpm_pkg::STATUS_OK;
                    n_state      = S_DONE;
                end else if (child != '0) begin
                    n_cur   = child;
                    n_level = r_level + 1'b1;
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end else if (!fresh_left) begin
                    n_res_hit    = 1'b0;
                    n_res_hop    = '0;
                    n_res_status = btpm_pkg::STATUS_FULL;
                    n_state      = S_DONE;
                end else begin
                    // Link the first new node into the existing trie.
                    if (r_cur == '0) begin
                        if (bit_now) begin
                            n_root_r = r_fresh[IDXW-1:0];
                        end else begin
                            n_root_l = r_fresh[IDXW-1:0];
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = bit_now ? {cur_left, r_fresh[IDXW-1:0], cur_route}
                                            : {r_fresh[IDXW-1:0], cur_right, cur_route};
                    end
                    n_cur   = r_fresh[IDXW-1:0];
                    n_fresh = r_fresh + 1'b1;
                    n_level = r_level + 1'b1;
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                // Each new node is written once with its final contents, since
                // every later node of the chain is also new.
                ram_we = 1'b1;
                if (r_level == r_len) begin
                    ram_wdata    = {{(2 * IDXW){1'b0}}, 1'b0, r_hop_in};
                    n_res_hit    = 1'b0;
                    n_res_hop    = '0;
                    n_res_status = btpm_pkg::STATUS_OK;
                    n_state      = S_DONE;
                end else if (!fresh_left) begin
                    ram_wdata    = {{(2 * IDXW){1'b0}}, btpm_pkg::NO_ROUTE};
                    n_res_hit    = 1'b0;
                    n_res_hop    = '0;
                    n_res_status = btpm_pkg::STATUS_FULL;
                    n_state      = S_DONE;
                end else begin
                    ram_wdata = bit_now
                        ? {{IDXW{1'b0}}, r_fresh[IDXW-1:0], btpm_pkg::NO_ROUTE}
                        : {r_fresh[IDXW-1:0], {IDXW{1'b0}}, btpm_pkg::NO_ROUTE};
                    n_cur   = r_fresh[IDXW-1:0];
                    n_fresh = r_fresh + 1'b1;
                    n_level = r_level + 1'b1;
                    n_addr  = {r_addr[ADDR_BITS-2:0], 1'b0};
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_hit    = r_res_hit;
                    n_out_hop    = r_res_hop;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fresh     <= (IDXW + 1)'(1);
            r_root_l    <= '0;
            r_root_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fresh     <= n_fresh;
            r_root_l    <= n_root_l;
            r_root_r    <= n_root_r;
        end
        r_is_lookup  <= n_is_lookup;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_level      <= n_level;
        r_cur        <= n_cur;
        r_hop_in     <= n_hop_in;
        r_hit        <= n_hit;
        r_hop        <= n_hop;
        r_res_hit    <= n_res_hit;
        r_res_hop    <= n_res_hop;
        r_res_status <= n_res_status;
        r_out_hit    <= n_out_hit;
        r_out_hop    <= n_out_hop;
        r_out_status <= n_out_status;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_hit      = r_out_hit;
    assign o_next_hop = r_out_hop;
    assign o_status   = r_out_status;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the binary trie longest prefix match block.
`timescale 1ns / 1ps

localparam int POOL_NODES = 4096;
localparam int KEY_BITS   = 128;

// Tracks the trie as the block should hold it and the lookup results still owed.
class trie_scoreboard;

    typedef struct packed {
        logic            hit;
        logic [7:0]      hop;
        logic            status;
    } t_lpm_result;

    logic [11:0]        left_kid  [POOL_NODES];
    logic [11:0]        right_kid [POOL_NODES];
    logic [8:0]         route_hop [POOL_NODES];
    int unsigned        nodes_taken;
    t_lpm_result        owed_q [$];

    int unsigned        errors;
    int unsigned        inserts;
    int unsigned        odd_lengths;
    int unsigned        full_inserts;
    int unsigned        lookups;
    int unsigned        lookup_hits;

    function new();
        for (int n = 0; n < POOL_NODES; n++) begin
            left_kid[n]  = '0;
            right_kid[n] = '0;
            route_hop[n] = btpm_pkg::NO_ROUTE;
        end
        nodes_taken  = 1;
        errors       = 0;
        inserts      = 0;
        odd_lengths  = 0;
        full_inserts = 0;
        lookups      = 0;
        lookup_hits  = 0;
    endfunction

    function int unsigned outstanding();
        return owed_q.size();
    endfunction

    function bit pool_exhausted();
        return full_inserts != 0;
    endfunction

    // Walks the trie for an accepted transaction and queues its result.
    function void note_request(logic kind, logic [127:0] key, logic [7:0] len,
                               logic [7:0] hop);
        t_lpm_result  want;
        int unsigned  cur;
        int unsigned  nxt;
        int unsigned  depth;
        int unsigned  lvl;
        bit           stop;
        logic         bit_now;

        want = '{hit: 1'b0, hop: 8'd0, status: btpm_pkg::STATUS_OK};
        cur  = 0;
        stop = 1'b0;
        if (kind == btpm_pkg::REQ_INSERT) begin
            inserts++;
            depth = (len > KEY_BITS) ? KEY_BITS : len;
            if (len == 0 || len > KEY_BITS) odd_lengths++;
            for (lvl = 0; lvl < depth && !stop; lvl++) begin
                bit_now = key[KEY_BITS - 1 - lvl];
                nxt = bit_now ? right_kid[cur] : left_kid[cur];
                if (nxt == 0) begin
                    if (nodes_taken >= POOL_NODES) begin
                        want.status = btpm_pkg::STATUS_FULL;
                        stop = 1'b1;
                    end else begin
                        nxt = nodes_taken;
                        nodes_taken++;
                        left_kid[nxt]  = '0;
                        right_kid[nxt] = '0;
                        route_hop[nxt] = btpm_pkg::NO_ROUTE;
                        if (bit_now) right_kid[cur] = nxt[11:0];
                        else left_kid[cur] = nxt[11:0];
                    end
                end
                if (!stop) cur = nxt;
            end
            if (stop) begin
                full_inserts++;
            end else if (depth > 0 && route_hop[cur] == btpm_pkg::NO_ROUTE) begin
                route_hop[cur] = {1'b0, hop};
            end
        end else begin
            lookups++;
            lvl = 0;
            while (!stop) begin
                if (route_hop[cur] != btpm_pkg::NO_ROUTE) begin
                    want.hit = 1'b1;
                    want.hop = route_hop[cur][7:0];
                end
                if (lvl >= KEY_BITS) begin
                    stop = 1'b1;
                end else begin
                    nxt = key[KEY_BITS - 1 - lvl] ? right_kid[cur] : left_kid[cur];
                    if (nxt == 0) stop = 1'b1;
                    else begin
                        cur = nxt;
                        lvl++;
                    end
                end
            end
            if (want.hit) lookup_hits++;
        end
        owed_q.push_back(want);
    endfunction

    function void report(string what, int exp_val, int got_val);
        errors++;
        if (errors <= 60)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val,
                     got_val);
    endfunction

    function void check_result(logic hit, logic [7:0] hop, logic status);
        t_lpm_result want;
        if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding, expected none actual %b/%0d/%b",
                     $time, hit, hop, status);
            return;
        end
        want = owed_q.pop_front();
        if (hit !== want.hit) report("hit", want.hit, hit);
        if (hop !== want.hop) report("next_hop", want.hop, hop);
        if (status !== want.status) report("status", want.status, status);
    endfunction

endclass

module tb;

    localparam int BASES       = 8;
    localparam int CYCLE_LIMIT = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_req_type;
    logic [63:0]       i_addr_hi;
    logic [63:0]       i_addr_lo;
    logic [7:0]        i_prefix_len;
    logic [7:0]        i_next_hop_in;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_hit;
    logic [7:0]        o_next_hop;
    logic              o_status;

    trie_scoreboard    sb;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       cycle_count   = 0;
    logic [127:0]      route_base [BASES];

    binary_trie_prefix_match #(
        .NODES     (POOL_NODES),
        .ADDR_BITS (KEY_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_addr_hi     (i_addr_hi),
        .i_addr_lo     (i_addr_lo),
        .i_prefix_len  (i_prefix_len),
        .i_next_hop_in (i_next_hop_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_next_hop    (o_next_hop),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                     sb.outstanding());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check every transaction taken, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_hit, o_next_hop, o_status);
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [127:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Keeps the top bits of one route base so that inserts and lookups share paths.
    function automatic logic [127:0] near_key(int unsigned which, int unsigned keep);
        logic [127:0] mask;
        mask = ~128'd0 << (KEY_BITS - keep);
        return (route_base[which] & mask) | (random_key() & ~mask);
    endfunction

    task automatic send_request(input logic kind, input logic [127:0] key,
                                input logic [7:0] len, input logic [7:0] hop);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= kind;
        i_addr_hi     <= key[127:64];
        i_addr_lo     <= key[63:0];
        i_prefix_len  <= len;
        i_next_hop_in <= hop;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(kind, key, len, hop);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned  pick;
        int unsigned  roll;
        int unsigned  which;
        int unsigned  len;
        logic [7:0]   hop;
        logic [7:0]   noise_len;

        pick      = $urandom_range(99);
        roll      = $urandom_range(99);
        which     = $urandom_range(BASES - 1);
        hop       = 8'($urandom_range(255));
        noise_len = 8'($urandom_range(255));
        if (pick < 45) begin
            if (roll < 5) len = 0;
            else if (roll < 10) len = $urandom_range(255, 129);
            else if (roll < 75) len = $urandom_range(48, 1);
            else len = $urandom_range(128, 49);
            send_request(btpm_pkg::REQ_INSERT, near_key(which, $urandom_range(128)),
                         len[7:0], hop);
        end else if (pick < 92) begin
            send_request(btpm_pkg::REQ_LOOKUP, near_key(which, $urandom_range(128, 8)),
                         noise_len, hop);
        end else begin
            send_request(btpm_pkg::REQ_LOOKUP, random_key(), noise_len, hop);
        end
    endtask

    initial begin
        sb = new();
        for (int b = 0; b < BASES; b++) route_base[b] = random_key();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_req_type    <= btpm_pkg::REQ_INSERT;
        i_addr_hi     <= '0;
        i_addr_lo     <= '0;
        i_prefix_len  <= '0;
        i_next_hop_in <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 60;

        // Empty trie, then a zero-length insert that must leave it empty.
        send_request(btpm_pkg::REQ_LOOKUP, '0, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_INSERT, '1, 8'd0, 8'h5A);
        send_request(btpm_pkg::REQ_LOOKUP, '1, 8'hFF, 8'hFF);
        // The first insert of a prefix keeps its next hop.
        send_request(btpm_pkg::REQ_INSERT, '1, 8'd128, 8'hFF);
        send_request(btpm_pkg::REQ_INSERT, '1, 8'd128, 8'h01);
        send_request(btpm_pkg::REQ_LOOKUP, '1, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_INSERT, {1'b1, 127'd0}, 8'd1, 8'h00);
        send_request(btpm_pkg::REQ_LOOKUP, {1'b1, 127'd0}, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_LOOKUP, '1, 8'd0, 8'd0);
        // Lengths above the address width act as full-length prefixes.
        send_request(btpm_pkg::REQ_INSERT, '0, 8'd255, 8'hA5);
        send_request(btpm_pkg::REQ_LOOKUP, '0, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_LOOKUP, 128'd1, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_INSERT, {2{64'h5555_5555_5555_5555}}, 8'd129, 8'h3C);
        send_request(btpm_pkg::REQ_INSERT, {2{64'h5555_5555_5555_5555}}, 8'd64, 8'h77);
        send_request(btpm_pkg::REQ_LOOKUP,
                     {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5554}, 8'd7, 8'h99);
        send_request(btpm_pkg::REQ_LOOKUP, {2{64'h5555_5555_5555_5555}}, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_INSERT, {64'hAAAA_AAAA_AAAA_AAAA, 64'd0}, 8'd64, 8'hC3);
        send_request(btpm_pkg::REQ_LOOKUP,
                     {64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_INSERT, '1, 8'd8, 8'h11);
        send_request(btpm_pkg::REQ_LOOKUP, {64'hFF00_0000_0000_0000, 64'd0}, 8'd0, 8'd0);
        send_request(btpm_pkg::REQ_LOOKUP, '1, 8'd0, 8'd0);
        wait_for_results();

        for (int n = 0; n < 500; n++) begin
            if (n == 170) begin
                send_idle_pct = 60;
                recv_idle_pct = 18;
            end else if (n == 340) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 250) wait_for_results();
            random_item();
        end

        // Long random prefixes until the node pool runs out, with lookups in between.
        while (!sb.pool_exhausted()) begin
            send_request(btpm_pkg::REQ_INSERT, random_key(), 8'd128,
                         8'($urandom_range(255)));
            random_item();
        end
        random_item();
        random_item();

        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (KEY_BITS + 8) @(posedge i_clk);

        $display("Run covered %0d inserts (%0d with zero or overlong length, %0d on a full pool)",
                 sb.inserts, sb.odd_lengths, sb.full_inserts);
        $display("and %0d lookups (%0d hits); the trie grew to %0d of %0d nodes.",
                 sb.lookups, sb.lookup_hits, sb.nodes_taken, POOL_NODES);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", sb.errors,
                     sb.outstanding());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/btpm_pkg.sv
sv/btpm_node_ram.sv
sv/binary_trie_prefix_match.sv
tb/sv/tb.sv
